// ===== sv/ssec_pkg.sv =====
// ----------------------------------------------------------------------------
// ssec_pkg
// Shared types and constants for the sorted set engine: request and status
// codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package ssec_pkg;

   localparam int CAPACITY_DEF = 16;

   // request kinds (kind 3 behaves like a search)
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_SEARCH = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   // register map
   localparam logic REG_ORDER = 1'b0;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_PLACE,
      S_DONE
   } ssec_state_type;

   typedef struct packed {
      logic load;        // capture request, start scan
      logic scan;        // scan step
      logic shift_init;  // set up the move pass
      logic shift;       // move step
      logic place;       // write the new value
      logic finish;      // load the response register
   } ssec_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic do_ins;
      logic do_rm;
      logic shift_done;
      logic shift_ins;
      logic rsp_busy;
   } ssec_sts_type;

endpackage

`default_nettype wire

// ===== sv/ssec_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssec_ctrl
// Controller: sequences scan, move, place and response for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module ssec_ctrl
   import ssec_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire ssec_sts_type sts,
   output ssec_cmd_type      cmd
);

   ssec_state_type state_ff;
   ssec_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               if (sts.do_ins || sts.do_rm) begin
                  cmd.shift_init = 1'b1;
                  state_in       = S_SHIFT;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (sts.shift_done) begin
               state_in = sts.shift_ins ? S_PLACE : S_DONE;
            end
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            // wait for the response register to free up
            if (!sts.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

`default_nettype wire

// ===== sv/ssec_dpath.sv =====
// ----------------------------------------------------------------------------
// ssec_dpath
// Datapath: entry memory, scan compare, move pipeline, element count and
// response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssec_dpath
   import ssec_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ssec_cmd_type        cmd,
   output ssec_sts_type             sts,
   input  wire logic [1:0]          req_kind,
   input  wire logic signed [31:0]  req_value,
   input  wire logic                order_desc,
   input  wire logic                rsp_stall,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic [4:0]               rsp_count
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE     = CW'(1);

   logic [31:0]        mem [CAPACITY];
   logic [31:0]        rd_data_ff;

   logic [1:0]         kind_ff;
   logic signed [31:0] value_ff;
   logic [CW-1:0]      held_ff, held_in;
   logic [CW-1:0]      ptr_ff;
   logic               chk_vld_ff;
   logic [IW-1:0]      chk_idx_ff;
   logic               found_ff;
   logic [IW-1:0]      pos_ff;
   logic               at_set_ff;
   logic [CW-1:0]      at_ff;
   logic               mode_ins_ff;
   logic               sh_vld_ff;
   logic [IW-1:0]      sh_dst_ff;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [4:0]         rsp_count_ff;

   logic               is_ins, is_rm, full;
   logic               scan_issue, shift_issue;
   logic               rd_en, wr_en;
   logic [IW-1:0]      rd_addr, wr_addr;
   logic [31:0]        wr_data;
   logic signed [31:0] entry;
   logic               prec;
   logic [CW-1:0]      ptr_dec, ptr_inc;
   logic [CW+4:0]      count_ext;

   assign is_ins  = (kind_ff == KIND_INSERT);
   assign is_rm   = (kind_ff == KIND_REMOVE);
   assign full    = (held_ff == CAP_CNT);
   assign ptr_dec = ptr_ff - ONE;
   assign ptr_inc = ptr_ff + ONE;

   assign scan_issue  = (ptr_ff < held_ff);
   assign shift_issue = mode_ins_ff ? (ptr_ff > at_ff) : (ptr_ff < held_ff);

   assign entry = rd_data_ff;
   assign prec  = order_desc ? (entry > value_ff) : (entry < value_ff);

   // memory ports
   always_comb begin
      rd_en   = (cmd.scan && scan_issue) || (cmd.shift && shift_issue);
      rd_addr = (cmd.shift && mode_ins_ff) ? ptr_dec[IW-1:0] : ptr_ff[IW-1:0];
      wr_en   = sh_vld_ff || cmd.place;
      wr_addr = cmd.place ? at_ff[IW-1:0] : sh_dst_ff;
      wr_data = cmd.place ? value_ff : rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // status and count of the finished request
   always_comb begin
      held_in = held_ff;
      if (is_ins) begin
         if (found_ff) begin
            rsp_status_in = ST_MISS;
         end else if (full) begin
            rsp_status_in = ST_FULL;
         end else begin
            rsp_status_in = ST_OK;
            held_in       = held_ff + ONE;
         end
      end else if (is_rm && found_ff) begin
         rsp_status_in = ST_OK;
         held_in       = held_ff - ONE;
      end else begin
         rsp_status_in = found_ff ? ST_OK : ST_MISS;
      end
   end

   assign count_ext = {5'b0, held_in};

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         chk_vld_ff   <= 1'b0;
         sh_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         chk_vld_ff <= cmd.scan && scan_issue;
         sh_vld_ff  <= cmd.shift && shift_issue;
         if (cmd.finish) begin
            held_ff      <= held_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload and pass registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_kind;
         value_ff  <= req_value;
         ptr_ff    <= '0;
         found_ff  <= 1'b0;
         pos_ff    <= '0;
         at_set_ff <= 1'b0;
         at_ff     <= held_ff;
      end else if (cmd.shift_init) begin
         mode_ins_ff <= sts.do_ins;
         ptr_ff      <= sts.do_ins ? held_ff : (CW'(pos_ff) + ONE);
      end else if (cmd.scan && scan_issue) begin
         ptr_ff     <= ptr_inc;
         chk_idx_ff <= ptr_ff[IW-1:0];
      end else if (cmd.shift && shift_issue) begin
         ptr_ff    <= mode_ins_ff ? ptr_dec : ptr_inc;
         sh_dst_ff <= mode_ins_ff ? ptr_ff[IW-1:0] : ptr_dec[IW-1:0];
      end

      // compare stage: first match and first slot that does not precede
      if (chk_vld_ff) begin
         if (!found_ff && (rd_data_ff == value_ff)) begin
            found_ff <= 1'b1;
            pos_ff   <= chk_idx_ff;
         end
         if (!at_set_ff && !prec) begin
            at_set_ff <= 1'b1;
            at_ff     <= CW'(chk_idx_ff);
         end
      end

      if (cmd.finish) begin
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= count_ext[4:0];
      end
   end

   always_comb begin
      sts.scan_done  = !scan_issue && !chk_vld_ff;
      sts.do_ins     = is_ins && !found_ff && !full;
      sts.do_rm      = is_rm && found_ff;
      sts.shift_done = !shift_issue && !sh_vld_ff;
      sts.shift_ins  = mode_ins_ff;
      sts.rsp_busy   = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

`default_nettype wire

// ===== sv/sorted_set_engine_core.sv =====
// ----------------------------------------------------------------------------
// sorted_set_engine_core
// Ordered table of distinct signed 32-bit values with insert, remove and
// search requests; one response (status, element count) per request.
//
// Request channel req_* and response channel rsp_* use valid/stall; a
// transfer happens when valid is high and stall is low. The order register
// (0 ascending, 1 descending) sits at byte address 0 of the csr_* port and
// must be written only while the engine is idle, which is not enforced.
// One request is worked on at a time: a scan of N memory reads, with N the
// element count, to find the match and insert slot, then a move pass of up
// to N entries through the entry memory (one entry per cycle), a write of
// the new value (inserts only) and the response load. Searches and rejected
// requests skip the move pass and the write.
// The response sits in an output register; the next request is taken the
// cycle after it loads. If rsp_stall holds, the following request finishes
// its work and then waits until the response register is free.
// Reset empties the table and selects ascending order; the entry memory is
// not cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_set_engine_core
   import ssec_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_kind,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [4:0]              rsp_count,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [2:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   ssec_cmd_type cmd;
   ssec_sts_type sts;
   logic         order_desc_ff;
   logic         csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_ORDER);

   always_ff @(posedge clock) begin
      if (reset) begin
         order_desc_ff <= 1'b0;
      end else if (csr_wr) begin
         order_desc_ff <= csr_pwdata[0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_ORDER) ? {31'b0, order_desc_ff} : 32'b0;

   ssec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ssec_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_kind   (req_kind),
      .req_value  (req_value),
      .order_desc (order_desc_ff),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count)
   );

endmodule

`default_nettype wire

// ===== sv/ssec_checker.sv =====
// ----------------------------------------------------------------------------
// ssec_checker
// Port-level checks for sorted_set_engine_core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ssec_checker
   import ssec_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_status,
   input wire logic [4:0] rsp_count
);

   localparam int CNT_MAX = (CAPACITY > 31) ? 31 : CAPACITY;
   localparam logic [4:0] CNT_FULL = 5'(CAPACITY);

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // one request in flight: a transfer closes the request side
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in progress");

   // full status only with a full table
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> (rsp_count == CNT_FULL))
      else $error("full status with free space");

   // count never exceeds the table size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_count) <= 32'(CNT_MAX)) || (CAPACITY > 31))
      else $error("count beyond capacity");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind sorted_set_engine_core ssec_checker #(
   .CAPACITY (CAPACITY)
) u_ssec_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_status (rsp_status),
   .rsp_count  (rsp_count)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sorted_set_engine_core. A queue-fed driver sends
// insert, remove and search requests, a shadow ordered table predicts each
// response, and a monitor checks status and count in order. Both channels
// idle at random. The order register is changed between phases while the
// engine is idle, and one long receiver hold-off forces the engine to back
// up into the request channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
   import ssec_pkg::*;
();

   localparam int          CAP         = CAPACITY_DEF;
   localparam logic [1:0]  KIND_SPARE  = 2'd3;     // unused code, acts like a search
   localparam logic [2:0]  ORDER_ADDR  = 3'(REG_ORDER) * 3'd4;
   localparam logic [2:0]  ADDR_UNUSED = 3'd4;
   localparam int          POOL_N      = 20;
   localparam int          PHASES      = 8;
   localparam int          PHASE_ITEMS = 140;
   localparam int          HOLD_LEN    = 400;
   localparam int          SETTLE      = 2 * CAP + 10;
   localparam int          LIMIT       = 400000;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] value;
   } set_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] count;
   } set_rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_kind = KIND_SEARCH;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic [4:0]         rsp_count;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [2:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   sorted_set_engine_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_kind    (req_kind),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_count   (rsp_count),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   set_req_type        request_q[$];
   set_rsp_type        expected_rsp_q[$];
   logic signed [31:0] held_vals[$];
   logic signed [31:0] pool[POOL_N];
   bit                 order_desc = 1'b0;
   bit                 req_fired = 1'b0;
   bit                 no_gaps = 1'b0;
   int                 holds_asked = 0;
   int                 holds_done = 0;
   int                 hold_left = 0;
   int                 errors = 0;
   int                 cycles = 0;
   int                 n_sent = 0;
   int                 n_ok = 0;
   int                 n_miss = 0;
   int                 n_full = 0;
   int                 peak_held = 0;
   int                 order_writes = 0;

   // shadow table: entries stay where they are when the order flips
   function automatic set_rsp_type apply_request(set_req_type r);
      int          hit;
      int          at;
      set_rsp_type res;
      hit = -1;
      foreach (held_vals[i])
         if (hit < 0 && held_vals[i] == r.value) hit = i;
      case (r.kind)
         KIND_INSERT: begin
            if (hit >= 0) begin
               res.status = ST_MISS;
            end else if (held_vals.size() >= CAP) begin
               res.status = ST_FULL;
            end else begin
               at = 0;
               while (at < held_vals.size() &&
                      (order_desc ? held_vals[at] > r.value : held_vals[at] < r.value))
                  at++;
               held_vals.insert(at, r.value);
               res.status = ST_OK;
            end
         end
         KIND_REMOVE: begin
            if (hit >= 0) begin
               held_vals.delete(hit);
               res.status = ST_OK;
            end else begin
               res.status = ST_MISS;
            end
         end
         default: res.status = (hit >= 0) ? ST_OK : ST_MISS;
      endcase
      res.count = 5'(held_vals.size());
      if (held_vals.size() > peak_held) peak_held = held_vals.size();
      return res;
   endfunction

   // mode 0 balanced, 1 insert-heavy, 2 remove-heavy
   function automatic set_req_type pick_request(int mode);
      set_req_type r;
      int          roll;
      int          ins_lim;
      int          rm_lim;
      roll    = $urandom_range(99);
      ins_lim = (mode == 1) ? 60 : (mode == 2) ? 25 : 40;
      rm_lim  = (mode == 1) ? 75 : (mode == 2) ? 70 : 65;
      if (roll < ins_lim)     r.kind = KIND_INSERT;
      else if (roll < rm_lim) r.kind = KIND_REMOVE;
      else if (roll < 94)     r.kind = KIND_SEARCH;
      else                    r.kind = KIND_SPARE;
      if ($urandom_range(99) < 85) r.value = pool[$urandom_range(POOL_N - 1)];
      else                         r.value = $urandom;
      return r;
   endfunction

   task automatic add_req(input logic [1:0] kind, input logic signed [31:0] value);
      set_req_type r;
      r.kind  = kind;
      r.value = value;
      request_q.push_back(r);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ORDER_ADDR) begin
         order_desc = data[0];
         order_writes++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_check_order();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ORDER_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {31'd0, order_desc}) begin
         $error("order_descending readback: expected %0d, got %0h", order_desc, csr_prdata);
         errors++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (request_q.size() != 0 || req_valid || expected_rsp_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic fill_pool(input bit with_extremes);
      for (int i = 0; i < POOL_N; i++) begin
         case ($urandom_range(3))
            0:       pool[i] = int'($urandom_range(40)) - 20;
            1:       pool[i] = 32'h7fff_ffff - $urandom_range(3);
            2:       pool[i] = 32'h8000_0000 + $urandom_range(3);
            default: pool[i] = $urandom;
         endcase
      end
      if (with_extremes) begin
         pool[0] = 32'h7fff_ffff;
         pool[1] = 32'h8000_0000;
      end
   endtask

   // request driver
   always @(negedge clock) begin : drive_req
      set_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (request_q.size() != 0 && (no_gaps || $urandom_range(99) >= 36)) begin
            nxt = request_q.pop_front();
            req_valid <= 1'b1;
            req_kind  <= nxt.kind;
            req_value <= nxt.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall, with the occasional long hold-off
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_done != holds_asked) begin
         rsp_stall  <= 1'b1;
         hold_left  <= HOLD_LEN;
         holds_done <= holds_done + 1;
      end else begin
         rsp_stall <= !no_gaps && ($urandom_range(99) < 36);
      end
   end

   // predict on each request transfer, check each response transfer
   always @(posedge clock) begin : monitor
      set_req_type r;
      set_rsp_type exp_rsp;
      req_fired <= req_valid && !req_stall && !reset;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $error("unexpected response: status %0d count %0d", rsp_status, rsp_count);
               errors++;
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               if (rsp_status !== exp_rsp.status) begin
                  $error("status: expected %0d, got %0d", exp_rsp.status, rsp_status);
                  errors++;
               end
               if (rsp_count !== exp_rsp.count) begin
                  $error("count: expected %0d, got %0d", exp_rsp.count, rsp_count);
                  errors++;
               end
               case (exp_rsp.status)
                  ST_OK:   n_ok++;
                  ST_MISS: n_miss++;
                  default: n_full++;
               endcase
            end
         end
         if (req_valid && !req_stall) begin
            r.kind  = req_kind;
            r.value = req_value;
            expected_rsp_q.push_back(apply_request(r));
            n_sent++;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycles, expected_rsp_q.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      bit ph_order[PHASES];
      int ph_mode[PHASES];
      ph_order = '{1, 0, 1, 1, 0, 0, 1, 0};
      ph_mode  = '{0, 1, 0, 2, 1, 0, 1, 2};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_write(ORDER_ADDR, 32'd0);
      csr_write(ADDR_UNUSED, 32'd1);   // no register there, must not touch the order
      csr_check_order();

      // directed: extremes, duplicates, misses, the spare kind, fill to full
      add_req(KIND_INSERT, 32'sd0);
      add_req(KIND_INSERT, 32'h7fff_ffff);
      add_req(KIND_INSERT, 32'h8000_0000);
      add_req(KIND_INSERT, -32'sd1);
      add_req(KIND_INSERT, 32'sd1);
      add_req(KIND_INSERT, 32'sd0);
      add_req(KIND_SEARCH, 32'h7fff_ffff);
      add_req(KIND_SEARCH, 32'sd5);
      add_req(KIND_SPARE, -32'sd1);
      add_req(KIND_SPARE, 32'sd7);
      add_req(KIND_REMOVE, 32'sd0);
      add_req(KIND_REMOVE, 32'sd0);
      for (int i = 0; i < 12; i++) add_req(KIND_INSERT, 32'sd100 + i);
      add_req(KIND_INSERT, 32'sd200);   // full
      add_req(KIND_INSERT, 32'sd1);     // duplicate while full
      wait_drained();

      for (int ph = 0; ph < PHASES; ph++) begin
         // upper data bits are don't-care for the order register
         csr_write(ORDER_ADDR, {31'($urandom_range(32'h7fff_ffff)), ph_order[ph]});
         csr_check_order();
         fill_pool(ph % 2 == 0);
         no_gaps = (ph == 2);
         if (ph == 5) begin
            // sender pauses mid-phase until all responses are back
            for (int i = 0; i < PHASE_ITEMS / 2; i++)
               request_q.push_back(pick_request(ph_mode[ph]));
            wait_drained();
            repeat ($urandom_range(20, 5)) @(posedge clock);
            for (int i = PHASE_ITEMS / 2; i < PHASE_ITEMS; i++)
               request_q.push_back(pick_request(ph_mode[ph]));
         end else begin
            for (int i = 0; i < PHASE_ITEMS; i++)
               request_q.push_back(pick_request(ph_mode[ph]));
         end
         if (ph == 4) holds_asked++;
         wait_drained();
      end

      no_gaps = 1'b0;
      repeat (SETTLE) @(posedge clock);
      $display("Sent %0d requests under %0d order writes, peak count %0d",
               n_sent, order_writes, peak_held);
      $display("Responses: %0d done/found, %0d duplicate/absent, %0d full",
               n_ok, n_miss, n_full);
      if (errors == 0 && expected_rsp_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
